@@ src/pdt_pkg.sv @@
// Shared types and constants for the per-pid delta ranking block.
// Used by the controller, the datapath and the ranked list modules.
package pdt_pkg;

    localparam int KB_BITS      = 40;
    localparam int DELTA_BITS   = 41;
    localparam int ROUND_BITS   = 16;
    localparam int STAMP_BITS   = 17;
    localparam int RANK_BITS    = 4;
    localparam int LIST_ID_BITS = 2;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [LIST_ID_BITS-1:0] LIST_GROW   = 2'd0;
    localparam logic [LIST_ID_BITS-1:0] LIST_SHRINK = 2'd1;
    localparam logic [LIST_ID_BITS-1:0] LIST_LARGE  = 2'd2;
    localparam logic [LIST_ID_BITS-1:0] LIST_EMPTY  = 2'd3;

    localparam logic OP_SAMPLE    = 1'b0;
    localparam logic OP_END_ROUND = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_CHANGE  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LIST_LENGTH = 1'd1;

    localparam logic [KB_BITS-1:0] MIN_CHANGE_RESET  = 40'd1024;
    localparam logic [3:0]         LIST_LENGTH_RESET = 4'd12;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_QUAL,
        ST_INS,
        ST_EMIT,
        ST_ROTATE
    } ctrl_state_t;

    typedef struct packed {
        logic ready;
        logic accept;
        logic clr_en;
        logic calc;
        logic qual;
        logic ins;
        logic emit_start;
        logic emit_step;
        logic rotate;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic take;
        logic emit_done;
        logic out_free;
    } dp_sts_t;

endpackage

@@ src/pdt_rank_list.sv @@
// One ranked list: sorted shift-insert register file with a read port.
// Depends on pdt_pkg for field widths.
module pdt_rank_list #(
    parameter int TOP_ENTRIES = 12,
    parameter int PID_BITS    = 15,
    parameter int FILLW       = 4,
    parameter int IDXW        = 4
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 clr,
    input  logic                                 ins_en,
    input  logic [FILLW-1:0]                     cap,
    input  logic signed [pdt_pkg::DELTA_BITS-1:0] key_in,
    input  logic [PID_BITS-1:0]                  pid_in,
    input  logic [pdt_pkg::KB_BITS-1:0]          res_in,
    input  logic [pdt_pkg::KB_BITS-1:0]          dat_in,
    input  logic [pdt_pkg::DELTA_BITS-1:0]       rd_in,
    input  logic [pdt_pkg::DELTA_BITS-1:0]       dd_in,
    input  logic [IDXW-1:0]                      rd_idx,
    output logic [PID_BITS-1:0]                  pid_out,
    output logic [pdt_pkg::KB_BITS-1:0]          res_out,
    output logic [pdt_pkg::KB_BITS-1:0]          dat_out,
    output logic [pdt_pkg::DELTA_BITS-1:0]       rd_out,
    output logic [pdt_pkg::DELTA_BITS-1:0]       dd_out,
    output logic [FILLW-1:0]                     fill_out
);

    logic signed [pdt_pkg::DELTA_BITS-1:0] key_reg [TOP_ENTRIES];
    logic [PID_BITS-1:0]                   pid_reg [TOP_ENTRIES];
    logic [pdt_pkg::KB_BITS-1:0]           res_reg [TOP_ENTRIES];
    logic [pdt_pkg::KB_BITS-1:0]           dat_reg [TOP_ENTRIES];
    logic [pdt_pkg::DELTA_BITS-1:0]        rdl_reg [TOP_ENTRIES];
    logic [pdt_pkg::DELTA_BITS-1:0]        ddl_reg [TOP_ENTRIES];
    logic [FILLW-1:0]                      fill_reg;
    logic [FILLW-1:0]                      fill_next;
    logic [FILLW-1:0]                      fill_c;
    logic [TOP_ENTRIES-1:0]                ge;
    logic [TOP_ENTRIES-1:0]                place;
    logic                                  ok;

    always_comb begin
        fill_c = (fill_reg > cap) ? cap : fill_reg;
        for (int i = 0; i < TOP_ENTRIES; i++) begin
            ge[i] = (FILLW'(i) < fill_c) && (key_reg[i] >= key_in);
        end
        for (int i = 0; i < TOP_ENTRIES; i++) begin
            place[i] = !ge[i] && ((i == 0) ? 1'b1 : ge[(i == 0) ? 0 : i - 1]);
        end
        ok = !ge[IDXW'(cap - 1'b1)];
        if (ok) begin
            fill_next = (fill_c < cap) ? fill_c + 1'b1 : cap;
        end else begin
            fill_next = fill_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (clr) begin
            fill_reg <= '0;
        end else if (ins_en) begin
            fill_reg <= fill_next;
        end
    end

    for (genvar g = 0; g < TOP_ENTRIES; g++) begin : g_ent
        always_ff @(posedge aclk) begin
            if (ins_en && ok && !ge[g]) begin
                if (place[g]) begin
                    key_reg[g] <= key_in;
                    pid_reg[g] <= pid_in;
                    res_reg[g] <= res_in;
                    dat_reg[g] <= dat_in;
                    rdl_reg[g] <= rd_in;
                    ddl_reg[g] <= dd_in;
                end else if (g > 0) begin
                    key_reg[g] <= key_reg[(g > 0) ? g - 1 : 0];
                    pid_reg[g] <= pid_reg[(g > 0) ? g - 1 : 0];
                    res_reg[g] <= res_reg[(g > 0) ? g - 1 : 0];
                    dat_reg[g] <= dat_reg[(g > 0) ? g - 1 : 0];
                    rdl_reg[g] <= rdl_reg[(g > 0) ? g - 1 : 0];
                    ddl_reg[g] <= ddl_reg[(g > 0) ? g - 1 : 0];
                end
            end
        end
    end

    assign pid_out  = pid_reg[rd_idx];
    assign res_out  = res_reg[rd_idx];
    assign dat_out  = dat_reg[rd_idx];
    assign rd_out   = rdl_reg[rd_idx];
    assign dd_out   = ddl_reg[rd_idx];
    assign fill_out = fill_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ins_en && !clr |=> fill_reg <= FILLW'(TOP_ENTRIES))
        else $error("ranked list fill beyond capacity");

endmodule

@@ src/pdt_datapath.sv @@
// Datapath: pid stamp and last-value memories, delta math, three ranked
// lists, configuration registers and the result register. Uses pdt_pkg.
module pdt_datapath #(
    parameter int PID_BITS    = 15,
    parameter int TOP_ENTRIES = 12,
    parameter int ROUND_LIMIT = 4096,
    parameter int IN_W        = 96,
    parameter int OUT_W       = 184
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  pdt_pkg::dp_cmd_t                      cmd,
    output pdt_pkg::dp_sts_t                      sts,
    input  logic [IN_W-1:0]                       s_tdata,
    input  logic [1:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [OUT_W-1:0]                      m_tdata,
    output logic [pdt_pkg::LIST_ID_BITS-1:0]      m_tuser,
    output logic                                  m_tlast,
    input  logic                                  cfg_we,
    input  logic [pdt_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [pdt_pkg::KB_BITS-1:0]           cfg_wdata
);

    localparam int KB    = pdt_pkg::KB_BITS;
    localparam int DW    = pdt_pkg::DELTA_BITS;
    localparam int DEPTH = 1 << PID_BITS;
    localparam int CNTW  = $clog2(ROUND_LIMIT + 1);
    localparam int FILLW = $clog2(TOP_ENTRIES + 1);
    localparam int IDXW  = (TOP_ENTRIES > 1) ? $clog2(TOP_ENTRIES) : 1;
    localparam int OPAD  = OUT_W - (pdt_pkg::RANK_BITS + PID_BITS + 2 * KB + 2 * DW);

    logic [pdt_pkg::STAMP_BITS-1:0] stamp_mem [DEPTH];
    logic [2*KB-1:0]                last_mem  [DEPTH];

    logic [PID_BITS-1:0] in_pid;
    logic [KB-1:0]       in_res;
    logic [KB-1:0]       in_dat;

    logic [PID_BITS-1:0]            pid_reg;
    logic [KB-1:0]                  res_reg;
    logic [KB-1:0]                  dat_reg;
    logic                           readable_reg;
    logic [pdt_pkg::STAMP_BITS-1:0] stamp_rd_reg;
    logic [2*KB-1:0]                last_rd_reg;
    logic [pdt_pkg::ROUND_BITS-1:0] round_reg;
    logic [CNTW-1:0]                samples_reg;
    logic signed [DW-1:0]           rd_reg;
    logic signed [DW-1:0]           dd_reg;
    logic                           hit_reg;
    logic                           qual_reg;
    logic [KB-1:0]                  min_reg;
    logic [3:0]                     len_reg;
    logic [PID_BITS-1:0]            clr_addr_reg;
    logic                           clr_done_reg;

    logic [pdt_pkg::LIST_ID_BITS-1:0] em_list_reg;
    logic [FILLW-1:0]                 em_idx_reg;
    logic                             em_any_reg;
    logic                             em_fin_reg;

    logic                             out_valid_reg;
    logic [pdt_pkg::LIST_ID_BITS-1:0] out_list_reg;
    logic [pdt_pkg::RANK_BITS-1:0]    out_rank_reg;
    logic [PID_BITS-1:0]              out_pid_reg;
    logic [KB-1:0]                    out_res_reg;
    logic [KB-1:0]                    out_dat_reg;
    logic [DW-1:0]                    out_rd_reg;
    logic [DW-1:0]                    out_dd_reg;
    logic                             out_last_reg;
    logic                             out_set;

    logic                           st_we;
    logic [PID_BITS-1:0]            st_waddr;
    logic [pdt_pkg::STAMP_BITS-1:0] st_wdata;
    logic [pdt_pkg::ROUND_BITS-1:0] prev_round;
    logic [DW-1:0]                  abs_r;
    logic [DW-1:0]                  abs_d;
    logic [FILLW-1:0]               cap;

    logic signed [DW-1:0] l_key  [3];
    logic                 l_ins  [3];
    logic [PID_BITS-1:0]  l_pid  [3];
    logic [KB-1:0]        l_res  [3];
    logic [KB-1:0]        l_dat  [3];
    logic [DW-1:0]        l_rd   [3];
    logic [DW-1:0]        l_dd   [3];
    logic [FILLW-1:0]     l_fill [3];
    logic [FILLW-1:0]     l_n    [3];

    logic [FILLW-1:0] cur_n;
    logic             rest_empty;

    assign in_pid = s_tdata[PID_BITS-1:0];
    assign in_res = s_tdata[PID_BITS +: KB];
    assign in_dat = s_tdata[PID_BITS + KB +: KB];

    always_comb begin
        if (len_reg == 4'd0) begin
            cap = FILLW'(1);
        end else if (int'(len_reg) > TOP_ENTRIES) begin
            cap = FILLW'(TOP_ENTRIES);
        end else begin
            cap = FILLW'(len_reg);
        end
        prev_round = round_reg - 1'b1;
        abs_r = rd_reg[DW-1] ? DW'(-rd_reg) : DW'(rd_reg);
        abs_d = dd_reg[DW-1] ? DW'(-dd_reg) : DW'(dd_reg);
        st_we    = cmd.clr_en || cmd.calc;
        st_waddr = cmd.clr_en ? clr_addr_reg : pid_reg;
        st_wdata = cmd.clr_en ? '0 : {1'b1, round_reg};
    end

    always_ff @(posedge aclk) begin
        if (st_we) begin
            stamp_mem[st_waddr] <= st_wdata;
        end
        if (cmd.accept) begin
            stamp_rd_reg <= stamp_mem[in_pid];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            last_mem[pid_reg] <= {dat_reg, res_reg};
        end
        if (cmd.accept) begin
            last_rd_reg <= last_mem[in_pid];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pid_reg      <= in_pid;
            res_reg      <= in_res;
            dat_reg      <= in_dat;
            readable_reg <= s_tuser[1];
        end
        if (cmd.calc) begin
            rd_reg  <= $signed({1'b0, res_reg}) - $signed({1'b0, last_rd_reg[KB-1:0]});
            dd_reg  <= $signed({1'b0, dat_reg}) - $signed({1'b0, last_rd_reg[2*KB-1:KB]});
            hit_reg <= stamp_rd_reg[pdt_pkg::STAMP_BITS-1]
                       && (stamp_rd_reg[pdt_pkg::ROUND_BITS-1:0] == prev_round);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            round_reg    <= '0;
            samples_reg  <= '0;
            qual_reg     <= 1'b0;
            min_reg      <= pdt_pkg::MIN_CHANGE_RESET;
            len_reg      <= pdt_pkg::LIST_LENGTH_RESET;
            clr_addr_reg <= '0;
            clr_done_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    pdt_pkg::CFG_MIN_CHANGE:  min_reg <= cfg_wdata;
                    pdt_pkg::CFG_LIST_LENGTH: len_reg <= cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (cmd.clr_en) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1) begin
                    clr_done_reg <= 1'b1;
                end
            end
            if (cmd.calc) begin
                samples_reg <= samples_reg + 1'b1;
            end
            if (cmd.qual) begin
                qual_reg <= hit_reg && ((abs_r >= {1'b0, min_reg}) || (abs_d >= {1'b0, min_reg}));
            end
            if (cmd.rotate) begin
                round_reg   <= round_reg + 1'b1;
                samples_reg <= '0;
            end
        end
    end

    assign l_key[0] = rd_reg;
    assign l_key[1] = DW'(-rd_reg);
    assign l_key[2] = $signed({1'b0, res_reg});
    assign l_ins[0] = cmd.ins && qual_reg && !rd_reg[DW-1] && (rd_reg != '0);
    assign l_ins[1] = cmd.ins && qual_reg && rd_reg[DW-1];
    assign l_ins[2] = cmd.ins && qual_reg;

    for (genvar g = 0; g < 3; g++) begin : g_list
        pdt_rank_list #(
            .TOP_ENTRIES(TOP_ENTRIES),
            .PID_BITS   (PID_BITS),
            .FILLW      (FILLW),
            .IDXW       (IDXW)
        ) u_list (
            .aclk    (aclk),
            .aresetn (aresetn),
            .clr     (cmd.rotate),
            .ins_en  (l_ins[g]),
            .cap     (cap),
            .key_in  (l_key[g]),
            .pid_in  (pid_reg),
            .res_in  (res_reg),
            .dat_in  (dat_reg),
            .rd_in   (rd_reg),
            .dd_in   (dd_reg),
            .rd_idx  (em_idx_reg[IDXW-1:0]),
            .pid_out (l_pid[g]),
            .res_out (l_res[g]),
            .dat_out (l_dat[g]),
            .rd_out  (l_rd[g]),
            .dd_out  (l_dd[g]),
            .fill_out(l_fill[g])
        );
        assign l_n[g] = (l_fill[g] < cap) ? l_fill[g] : cap;
    end

    always_comb begin
        case (em_list_reg)
            pdt_pkg::LIST_GROW: begin
                cur_n      = l_n[0];
                rest_empty = (l_n[1] == '0) && (l_n[2] == '0);
            end
            pdt_pkg::LIST_SHRINK: begin
                cur_n      = l_n[1];
                rest_empty = (l_n[2] == '0);
            end
            pdt_pkg::LIST_LARGE: begin
                cur_n      = l_n[2];
                rest_empty = 1'b1;
            end
            default: begin
                cur_n      = '0;
                rest_empty = 1'b1;
            end
        endcase
    end

    always_comb begin
        out_set = 1'b0;
        if (cmd.emit_step) begin
            if (em_list_reg != pdt_pkg::LIST_EMPTY) begin
                out_set = (em_idx_reg < cur_n);
            end else begin
                out_set = !em_any_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            em_list_reg   <= pdt_pkg::LIST_GROW;
            em_idx_reg    <= '0;
            em_any_reg    <= 1'b0;
            em_fin_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_set) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.emit_start) begin
                em_list_reg <= pdt_pkg::LIST_GROW;
                em_idx_reg  <= '0;
                em_any_reg  <= 1'b0;
                em_fin_reg  <= 1'b0;
            end else if (cmd.emit_step) begin
                if (em_list_reg != pdt_pkg::LIST_EMPTY) begin
                    if (em_idx_reg < cur_n) begin
                        em_any_reg <= 1'b1;
                        if (em_idx_reg == cur_n - 1'b1) begin
                            em_list_reg <= em_list_reg + 1'b1;
                            em_idx_reg  <= '0;
                        end else begin
                            em_idx_reg <= em_idx_reg + 1'b1;
                        end
                    end else begin
                        em_list_reg <= em_list_reg + 1'b1;
                        em_idx_reg  <= '0;
                    end
                end else begin
                    em_fin_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_step) begin
            if (em_list_reg != pdt_pkg::LIST_EMPTY) begin
                if (em_idx_reg < cur_n) begin
                    out_list_reg <= em_list_reg;
                    out_rank_reg <= pdt_pkg::RANK_BITS'(em_idx_reg);
                    out_pid_reg  <= l_pid[em_list_reg];
                    out_res_reg  <= l_res[em_list_reg];
                    out_dat_reg  <= l_dat[em_list_reg];
                    out_rd_reg   <= l_rd[em_list_reg];
                    out_dd_reg   <= l_dd[em_list_reg];
                    out_last_reg <= (em_idx_reg == cur_n - 1'b1) && rest_empty;
                end
            end else if (!em_any_reg) begin
                out_list_reg <= pdt_pkg::LIST_EMPTY;
                out_rank_reg <= '0;
                out_pid_reg  <= '0;
                out_res_reg  <= '0;
                out_dat_reg  <= '0;
                out_rd_reg   <= '0;
                out_dd_reg   <= '0;
                out_last_reg <= 1'b1;
            end
        end
    end

    assign sts.clear_done = clr_done_reg;
    assign sts.take       = readable_reg && (samples_reg < CNTW'(ROUND_LIMIT));
    assign sts.emit_done  = em_fin_reg;
    assign sts.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_list_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{OPAD{1'b0}}, out_dd_reg, out_rd_reg, out_dat_reg, out_res_reg,
                       out_pid_reg, out_rank_reg};

endmodule

@@ src/pdt_ctrl.sv @@
// Controller state machine: sequences clearing, sample update, ranking
// and end-of-round emission. Uses pdt_pkg for state and command types.
module pdt_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             in_op,
    input  pdt_pkg::dp_sts_t sts,
    output pdt_pkg::dp_cmd_t cmd
);

    pdt_pkg::ctrl_state_t state_reg;
    pdt_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pdt_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            pdt_pkg::ST_CLEAR: begin
                if (sts.clear_done) begin
                    state_next = pdt_pkg::ST_IDLE;
                end else begin
                    cmd.clr_en = 1'b1;
                end
            end
            pdt_pkg::ST_IDLE: begin
                cmd.ready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (in_op == pdt_pkg::OP_END_ROUND) begin
                        cmd.emit_start = 1'b1;
                        state_next     = pdt_pkg::ST_EMIT;
                    end else begin
                        state_next = pdt_pkg::ST_CALC;
                    end
                end
            end
            pdt_pkg::ST_CALC: begin
                if (sts.take) begin
                    cmd.calc   = 1'b1;
                    state_next = pdt_pkg::ST_QUAL;
                end else begin
                    state_next = pdt_pkg::ST_IDLE;
                end
            end
            pdt_pkg::ST_QUAL: begin
                cmd.qual   = 1'b1;
                state_next = pdt_pkg::ST_INS;
            end
            pdt_pkg::ST_INS: begin
                cmd.ins    = 1'b1;
                state_next = pdt_pkg::ST_IDLE;
            end
            pdt_pkg::ST_EMIT: begin
                if (sts.emit_done) begin
                    state_next = pdt_pkg::ST_ROTATE;
                end else begin
                    cmd.emit_step = sts.out_free;
                end
            end
            pdt_pkg::ST_ROTATE: begin
                cmd.rotate = 1'b1;
                state_next = pdt_pkg::ST_IDLE;
            end
            default: begin
                state_next = pdt_pkg::ST_IDLE;
            end
        endcase
    end

    a_sample_to_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept && in_op == pdt_pkg::OP_SAMPLE |=> state_reg == pdt_pkg::ST_CALC)
        else $error("sample item did not enter update");

    a_emit_to_rotate: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == pdt_pkg::ST_EMIT && sts.emit_done |=> state_reg == pdt_pkg::ST_ROTATE)
        else $error("end of emission did not rotate the round");

    a_clear_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == pdt_pkg::ST_CLEAR && !sts.clear_done |=> !cmd.ready)
        else $error("item accepted during clearing pass");

endmodule

@@ src/pid_delta_topn_tracker.sv @@
// Top level of the per-pid memory delta ranking block.
// Instantiates pdt_ctrl and pdt_datapath; uses pdt_pkg.
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  sample or end-of-round item
//   m_       out  m_tvalid/m_tready  one ranked entry per item
//   cfg_     in   cfg_we             register index and data
//
// A sample item steps through accept, stamp/value memory read-modify-write,
// threshold and list insert; a skipped sample returns to idle without the update.
// End of round emits the ranked entries list by list, skipping empty lists, or one
// LIST_EMPTY item if all lists are empty, then rotates the round; each emitted item
// also waits while m_tready holds the single result register.
// After reset every stamp memory address is cleared, with s_tready low.
module pid_delta_topn_tracker #(
    parameter int PID_BITS    = 15,
    parameter int TOP_ENTRIES = 12,
    parameter int ROUND_LIMIT = 4096
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // pid, resident_kb, data_seg_kb
    input  logic [((PID_BITS + 80 + 7) / 8) * 8 - 1:0]  s_tdata,
    // operation, readable
    input  logic [1:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // rank, out_pid, out_resident_kb, out_data_kb, resident_delta_kb, data_change_kb
    output logic [((PID_BITS + 166 + 7) / 8) * 8 - 1:0] m_tdata,
    // list_id
    output logic [pdt_pkg::LIST_ID_BITS-1:0]     m_tuser,
    output logic                                 m_tlast,
    input  logic                                 cfg_we,
    input  logic [pdt_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [pdt_pkg::KB_BITS-1:0]          cfg_wdata
);

    localparam int IN_W  = ((PID_BITS + 80 + 7) / 8) * 8;
    localparam int OUT_W = ((PID_BITS + 166 + 7) / 8) * 8;

    pdt_pkg::dp_cmd_t cmd;
    pdt_pkg::dp_sts_t sts;

    pdt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .in_op   (s_tuser[0]),
        .sts     (sts),
        .cmd     (cmd)
    );

    pdt_datapath #(
        .PID_BITS   (PID_BITS),
        .TOP_ENTRIES(TOP_ENTRIES),
        .ROUND_LIMIT(ROUND_LIMIT),
        .IN_W       (IN_W),
        .OUT_W      (OUT_W)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    assign s_tready = cmd.ready;

endmodule

@@ tb/tb.sv @@
// Self-checking bench for pid_delta_topn_tracker: drives sample and end-of-round items
// over the stream ports and checks every ranked result against a built-in predictor.
// Depends on pdt_pkg and the pid_delta_topn_tracker top level only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPID = 1 << 15;
    localparam int TOPN = 12;
    localparam int RLIMIT = 4096;
    localparam logic [39:0] KB_MAX = '1;

    typedef struct packed {
        logic [1:0]  list_id;
        logic [3:0]  rank;
        logic [14:0] pid;
        logic [39:0] res;
        logic [39:0] dat;
        logic [40:0] rdelta;
        logic [40:0] ddelta;
        logic        last;
    } rank_result_t;

    typedef struct {
        logic [14:0] pid;
        logic [39:0] res;
        logic [39:0] dat;
        longint      rdelta;
        longint      ddelta;
    } change_t;

    class delta_rank_board;
        logic [16:0]  stamp [NPID];
        logic [39:0]  prev_res [NPID];
        logic [39:0]  prev_dat [NPID];
        logic [15:0]  round_no;
        int           round_cnt;
        logic [39:0]  min_change;
        logic [3:0]   list_len;
        change_t      lists [3][$];
        rank_result_t pending_results [$];
        int           errors;

        function new();
            foreach (stamp[i]) stamp[i] = '0;
            round_no = '0;
            round_cnt = 0;
            min_change = pdt_pkg::MIN_CHANGE_RESET;
            list_len = pdt_pkg::LIST_LENGTH_RESET;
            errors = 0;
        endfunction

        function void set_reg(logic [pdt_pkg::CFG_IDX_BITS-1:0] idx, logic [39:0] val);
            if (idx == pdt_pkg::CFG_MIN_CHANGE) min_change = val;
            else if (idx == pdt_pkg::CFG_LIST_LENGTH) list_len = val[3:0];
        endfunction

        function int cap();
            if (list_len == 0) return 1;
            if (list_len > TOPN) return TOPN;
            return list_len;
        endfunction

        function longint key_of(int l, change_t c);
            if (l == pdt_pkg::LIST_GROW) return c.rdelta;
            if (l == pdt_pkg::LIST_SHRINK) return -c.rdelta;
            return longint'(c.res);
        endfunction

        function void place(int l, change_t c);
            int pos;
            int n;
            n = cap();
            while (lists[l].size() > n) void'(lists[l].pop_back());
            pos = 0;
            while (pos < lists[l].size() && key_of(l, lists[l][pos]) >= key_of(l, c)) pos++;
            if (pos >= n) return;
            lists[l].insert(pos, c);
            if (lists[l].size() > n) void'(lists[l].pop_back());
        endfunction

        function void note(logic op, logic [14:0] pid, logic rd, logic [39:0] res,
                           logic [39:0] dat);
            change_t c;
            longint ar, ad;
            rank_result_t r;
            rank_result_t run [$];
            int n;
            if (op == pdt_pkg::OP_SAMPLE) begin
                if (!rd || round_cnt >= RLIMIT) return;
                round_cnt++;
                if (stamp[pid][16] && stamp[pid][15:0] == round_no - 16'd1) begin
                    c.pid = pid;
                    c.res = res;
                    c.dat = dat;
                    c.rdelta = longint'(res) - longint'(prev_res[pid]);
                    c.ddelta = longint'(dat) - longint'(prev_dat[pid]);
                    ar = c.rdelta < 0 ? -c.rdelta : c.rdelta;
                    ad = c.ddelta < 0 ? -c.ddelta : c.ddelta;
                    if (ar >= longint'(min_change) || ad >= longint'(min_change)) begin
                        if (c.rdelta > 0) place(pdt_pkg::LIST_GROW, c);
                        if (c.rdelta < 0) place(pdt_pkg::LIST_SHRINK, c);
                        place(pdt_pkg::LIST_LARGE, c);
                    end
                end
                stamp[pid] = {1'b1, round_no};
                prev_res[pid] = res;
                prev_dat[pid] = dat;
            end else begin
                for (int l = 0; l < 3; l++) begin
                    n = lists[l].size() < cap() ? lists[l].size() : cap();
                    for (int i = 0; i < n; i++) begin
                        r.list_id = 2'(l);
                        r.rank = 4'(i);
                        r.pid = lists[l][i].pid;
                        r.res = lists[l][i].res;
                        r.dat = lists[l][i].dat;
                        r.rdelta = lists[l][i].rdelta[40:0];
                        r.ddelta = lists[l][i].ddelta[40:0];
                        r.last = 1'b0;
                        run.push_back(r);
                    end
                    lists[l].delete();
                end
                if (run.size() == 0) begin
                    r = '0;
                    r.list_id = pdt_pkg::LIST_EMPTY;
                    run.push_back(r);
                end
                run[run.size()-1].last = 1'b1;
                pending_results = {pending_results, run};
                round_no++;
                round_cnt = 0;
            end
        endfunction

        function void check(rank_result_t got);
            rank_result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got !== want) begin
                $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic                               aclk;
    logic                               aresetn;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [95:0]                        s_tdata;
    logic [1:0]                         s_tuser;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [183:0]                       m_tdata;
    logic [pdt_pkg::LIST_ID_BITS-1:0]   m_tuser;
    logic                               m_tlast;
    logic                               cfg_we;
    logic [pdt_pkg::CFG_IDX_BITS-1:0]   cfg_index;
    logic [pdt_pkg::KB_BITS-1:0]        cfg_wdata;

    delta_rank_board board = new();
    int tx_idle_pct;
    int rx_idle_pct;

    pid_delta_topn_tracker u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(negedge aclk) begin
        rank_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.list_id = m_tuser;
            got.rank = m_tdata[3:0];
            got.pid = m_tdata[18:4];
            got.res = m_tdata[58:19];
            got.dat = m_tdata[98:59];
            got.rdelta = m_tdata[139:99];
            got.ddelta = m_tdata[180:140];
            got.last = m_tlast;
            board.check(got);
        end
    end

    task automatic put_item(logic op, logic [14:0] pid, logic rd, logic [39:0] res,
                            logic [39:0] dat);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, dat, res, pid};
        s_tuser <= {rd, op};
        do @(negedge aclk); while (!s_tready);
        board.note(op, pid, rd, res, dat);
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [pdt_pkg::CFG_IDX_BITS-1:0] idx, logic [39:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        board.set_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [39:0] pick_kb();
        int sel;
        sel = $urandom_range(99);
        if (sel < 55) return 40'($urandom_range(8191));
        if (sel < 80) return {8'($urandom), 32'($urandom)};
        if (sel < 90) return '0;
        return KB_MAX;
    endfunction

    function automatic logic [14:0] pick_pid();
        if ($urandom_range(99) < 15) return 15'($urandom);
        if ($urandom_range(99) < 5) return 15'h7fff;
        return 15'($urandom_range(23));
    endfunction

    task automatic samples(int n);
        repeat (n) put_item(pdt_pkg::OP_SAMPLE, pick_pid(), $urandom_range(99) < 90,
                            pick_kb(), pick_kb());
    endtask

    task automatic rounds(int items);
        int n;
        while (items > 0) begin
            n = $urandom_range(20);
            if (n > items - 1) n = items - 1;
            samples(n);
            put_item(pdt_pkg::OP_END_ROUND, 15'($urandom), 1'($urandom), pick_kb(), pick_kb());
            items -= n + 1;
        end
    endtask

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        m_tready <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        tx_idle_pct = 32;
        rx_idle_pct = 77;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        put_item(pdt_pkg::OP_SAMPLE, 15'd0, 1'b1, 40'd100, 40'd100);
        put_item(pdt_pkg::OP_SAMPLE, 15'h7fff, 1'b1, KB_MAX, KB_MAX);
        put_item(pdt_pkg::OP_SAMPLE, 15'd7, 1'b1, KB_MAX, 40'd0);
        put_item(pdt_pkg::OP_SAMPLE, 15'd9, 1'b1, 40'd0, KB_MAX);
        put_item(pdt_pkg::OP_SAMPLE, 15'd3, 1'b1, 40'd5000, 40'd0);
        put_item(pdt_pkg::OP_SAMPLE, 15'd4, 1'b1, 40'd5000, 40'd0);
        put_item(pdt_pkg::OP_SAMPLE, 15'd5, 1'b0, 40'd1, 40'd1);
        put_item(pdt_pkg::OP_END_ROUND, 15'd0, 1'b0, 40'd0, 40'd0);
        put_item(pdt_pkg::OP_SAMPLE, 15'd0, 1'b1, 40'd1124, 40'd100);
        put_item(pdt_pkg::OP_SAMPLE, 15'h7fff, 1'b1, 40'd0, KB_MAX);
        put_item(pdt_pkg::OP_SAMPLE, 15'd7, 1'b1, 40'd0, KB_MAX);
        put_item(pdt_pkg::OP_SAMPLE, 15'd9, 1'b1, KB_MAX, 40'd0);
        put_item(pdt_pkg::OP_SAMPLE, 15'd3, 1'b1, 40'd3000, 40'd0);
        put_item(pdt_pkg::OP_SAMPLE, 15'd4, 1'b1, 40'd3000, 40'd0);
        put_item(pdt_pkg::OP_SAMPLE, 15'd5, 1'b1, 40'd1, 40'd1);
        put_item(pdt_pkg::OP_SAMPLE, 15'd0, 1'b1, 40'd9999, 40'd9);
        put_item(pdt_pkg::OP_SAMPLE, 15'd20, 1'b1, 40'd100, 40'd1123);
        put_item(pdt_pkg::OP_SAMPLE, 15'd7, 1'b0, 40'd77, 40'd77);
        put_item(pdt_pkg::OP_END_ROUND, 15'h7fff, 1'b1, KB_MAX, KB_MAX);
        put_item(pdt_pkg::OP_END_ROUND, 15'd0, 1'b0, 40'd0, 40'd0);
        drain();

        for (int p = 0; p < 6; p++) begin
            tx_idle_pct = (p < 2) ? 32 : (p < 4) ? 77 : 0;
            rx_idle_pct = (p < 2) ? 77 : (p < 4) ? 32 : 0;
            case (p)
                0: begin
                    write_reg(pdt_pkg::CFG_MIN_CHANGE, 40'd0);
                    write_reg(pdt_pkg::CFG_LIST_LENGTH, 40'd1);
                end
                1: begin
                    write_reg(pdt_pkg::CFG_MIN_CHANGE, KB_MAX);
                    write_reg(pdt_pkg::CFG_LIST_LENGTH, 40'd15);
                end
                2: begin
                    write_reg(pdt_pkg::CFG_MIN_CHANGE, 40'($urandom_range(3000)));
                    write_reg(pdt_pkg::CFG_LIST_LENGTH, 40'd0);
                end
                3: begin
                    write_reg(pdt_pkg::CFG_MIN_CHANGE, 40'd2000);
                    write_reg(pdt_pkg::CFG_LIST_LENGTH, 40'd5);
                end
                4: begin
                    write_reg(pdt_pkg::CFG_MIN_CHANGE, 40'd1024);
                    write_reg(pdt_pkg::CFG_LIST_LENGTH, 40'd12);
                end
                default: begin
                    write_reg(pdt_pkg::CFG_MIN_CHANGE, 40'd100);
                    write_reg(pdt_pkg::CFG_LIST_LENGTH, 40'd3);
                end
            endcase
            rounds(36);
            if (p == 1) begin
                put_item(pdt_pkg::OP_END_ROUND, 15'd0, 1'b1, 40'd0, 40'd0);
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (board.pending_results.size() != 0) @(posedge aclk);
                samples(10);
                put_item(pdt_pkg::OP_END_ROUND, 15'd0, 1'b1, 40'd0, 40'd0);
            end
            drain();
        end

        write_reg(pdt_pkg::CFG_LIST_LENGTH, 40'd12);
        write_reg(pdt_pkg::CFG_MIN_CHANGE, 40'd0);
        samples(30);
        put_item(pdt_pkg::OP_END_ROUND, 15'd0, 1'b1, 40'd0, 40'd0);
        samples(40);
        drain();
        write_reg(pdt_pkg::CFG_LIST_LENGTH, 40'd2);
        samples(5);
        put_item(pdt_pkg::OP_END_ROUND, 15'd0, 1'b1, 40'd0, 40'd0);
        repeat (10) put_item(pdt_pkg::OP_SAMPLE, 15'($urandom_range(40)), 1'b1, pick_kb(),
                             pick_kb());
        put_item(pdt_pkg::OP_END_ROUND, 15'd0, 1'b1, 40'd0, 40'd0);
        drain();
        write_reg(pdt_pkg::CFG_LIST_LENGTH, 40'd12);
        samples(20);
        put_item(pdt_pkg::OP_END_ROUND, 15'd0, 1'b1, 40'd0, 40'd0);
        drain();

        if (board.pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     board.pending_results.size());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

@@ sim.f @@
src/pdt_pkg.sv
src/pdt_rank_list.sv
src/pdt_datapath.sv
src/pdt_ctrl.sv
src/pid_delta_topn_tracker.sv
tb/tb.sv
